// ----- rtl/core/tccb_pkg.sv -----
// shared types and constants for the text console character buffer
package tccb_pkg;

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // character codes
  localparam logic [7:0] CH_BACKSPACE   = 8'd8;
  localparam logic [7:0] CH_NEWLINE     = 8'd10;
  localparam logic [7:0] CH_FIRST_PRINT = 8'd32;
  localparam logic [7:0] CH_LAST_PRINT  = 8'd126;
  localparam logic [6:0] CELL_SPACE     = 7'd32;

  // input request payload
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_t;

  // result payload
  typedef struct packed {
    logic [6:0] cell_char;
    logic [4:0] cursor_row_now;
    logic [6:0] cursor_col_now;
    logic       did_scroll;
  } out_t;

  // blanking sweep command
  typedef struct packed {
    logic go;
    logic all;
  } sweep_cmd_t;

endpackage

// ----- rtl/core/tccb_mem.sv -----
// single-port-write, single-port-read cell memory with registered read data
module tccb_mem #(
  parameter int AW = 12,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [0:(1<<AW)-1];
  logic [DW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/tccb_sweep.sv -----
// blanking sequencer: writes spaces over one physical row or the whole store
module tccb_sweep #(
  parameter int ROWS = 25,
  parameter int COLS = 80,
  parameter int RW   = 5,
  parameter int CW   = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tccb_pkg::sweep_cmd_t cmd,
  input  logic [RW-1:0]       cmd_row,
  output logic                busy,
  output logic [RW-1:0]       wr_row,
  output logic [CW-1:0]       wr_col
);
  import tccb_pkg::*;

  logic          busy_r, busy_nxt;
  logic          all_r, all_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;

  // walk columns, then rows when sweeping everything
  always_comb begin
    busy_nxt = busy_r;
    all_nxt  = all_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (cmd.go) begin
      busy_nxt = 1'b1;
      all_nxt  = cmd.all;
      row_nxt  = cmd.all ? '0 : cmd_row;
      col_nxt  = '0;
    end else if (busy_r) begin
      if (col_r == CW'(COLS - 1)) begin
        col_nxt = '0;
        if (!all_r || row_r == RW'(ROWS - 1)) begin
          busy_nxt = 1'b0;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  // reset starts a full clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      all_r  <= 1'b1;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      all_r  <= all_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  assign busy   = busy_r;
  assign wr_row = row_r;
  assign wr_col = col_r;

endmodule

// ----- rtl/core/text_console_char_buffer.sv -----
// top level of the text console character buffer
// Character-cell console store with a cursor, ROWS x COLS cells of 7 bits held in one
// synchronous memory addressed as {physical row, column}; screen rows map onto physical
// rows through a rotating top-row pointer, so a scroll only blanks one row. Writes,
// clears and unknown request types are answered in the cycle after acceptance; writes and
// unknown types can be taken every cycle while results drain. A read passes through the
// memory's registered read port and then the output register. A newline on the bottom row
// scrolls: the result is registered as for other writes and the block then blanks one row,
// taking no request. A clear blanks the whole store, and after reset the same clearing
// pass runs before the first request is taken.
module text_console_char_buffer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tccb_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tccb_pkg::out_t out_data
);
  import tccb_pkg::*;

  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLS);
  localparam int CCW = $clog2(COLS + 1);
  localparam int AW  = RW + CW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic           state_r, state_nxt;
  logic [RW-1:0]  cur_row_r, cur_row_nxt;
  logic [CCW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0]  top_r, top_nxt;
  logic           out_valid_r;
  out_t           out_data_r;
  logic           rd_ok_r;

  logic           accept;
  logic           scroll;
  logic           mem_wr_en;
  logic [AW-1:0]  mem_wr_addr;
  logic [6:0]     mem_wr_data;
  logic           req_wr_en;
  logic [CW-1:0]  req_wr_col;
  logic [6:0]     req_wr_data;
  logic [AW-1:0]  rd_addr;
  logic [6:0]     rd_data;
  logic           rd_ok;
  logic           load_now;
  out_t           res_now;
  sweep_cmd_t     sw_cmd;
  logic           sw_busy;
  logic [RW-1:0]  sw_row;
  logic [CW-1:0]  sw_col;

  // screen row to physical row through the rotating top pointer
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr,
                                             input logic [RW-1:0] top);
    logic [RW:0] s;
    s = {1'b0, lr} + {1'b0, top};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && !sw_busy && (!out_valid_r || out_ready);

  // request decode: cursor, store writes and sweep start
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    top_nxt     = top_r;
    scroll      = 1'b0;
    req_wr_en   = 1'b0;
    req_wr_col  = cur_col_r[CW-1:0];
    req_wr_data = CELL_SPACE;
    sw_cmd      = '0;
    state_nxt   = state_r;
    load_now    = 1'b0;
    if (state_r == ST_READ) begin
      state_nxt = ST_IDLE;
    end else if (accept) begin
      unique case (in_data.req_type)
        REQ_WRITE: begin
          load_now = 1'b1;
          if (in_data.char_code == CH_NEWLINE) begin
            cur_col_nxt = '0;
            if (cur_row_r == RW'(ROWS - 1)) begin
              scroll = 1'b1;
              top_nxt = (top_r == RW'(ROWS - 1)) ? '0 : top_r + 1'b1;
              sw_cmd.go = 1'b1;
            end else begin
              cur_row_nxt = cur_row_r + 1'b1;
            end
          end else if (in_data.char_code == CH_BACKSPACE) begin
            if (cur_col_r != '0) begin
              cur_col_nxt = cur_col_r - 1'b1;
              req_wr_en   = 1'b1;
              req_wr_col  = cur_col_nxt[CW-1:0];
            end
          end else if (in_data.char_code >= CH_FIRST_PRINT &&
                       in_data.char_code <= CH_LAST_PRINT) begin
            if (cur_col_r < CCW'(COLS)) begin
              cur_col_nxt = cur_col_r + 1'b1;
              req_wr_en   = 1'b1;
              req_wr_data = in_data.char_code[6:0];
            end
          end
        end
        REQ_READ: begin
          state_nxt = ST_READ;
        end
        REQ_CLEAR: begin
          load_now    = 1'b1;
          cur_row_nxt = '0;
          cur_col_nxt = '0;
          top_nxt     = '0;
          sw_cmd.go   = 1'b1;
          sw_cmd.all  = 1'b1;
        end
        default: begin
          load_now = 1'b1;
        end
      endcase
    end
  end

  // result for requests answered without a memory read
  always_comb begin
    res_now.cell_char      = '0;
    res_now.cursor_row_now = 5'(cur_row_nxt);
    res_now.cursor_col_now = 7'(cur_col_nxt);
    res_now.did_scroll     = scroll;
  end

  // read address and range check
  assign rd_ok   = (7'(in_data.read_row) < 7'(ROWS)) && (8'(in_data.read_col) < 8'(COLS));
  assign rd_addr = {phys_row(RW'(in_data.read_row), top_r), CW'(in_data.read_col)};

  // memory write mux: sweep owns the port while busy
  always_comb begin
    if (sw_busy) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = {sw_row, sw_col};
      mem_wr_data = CELL_SPACE;
    end else begin
      mem_wr_en   = req_wr_en;
      mem_wr_addr = {phys_row(cur_row_r, top_r), req_wr_col};
      mem_wr_data = req_wr_data;
    end
  end

  tccb_mem #(
    .AW (AW),
    .DW (7)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept && in_data.req_type == REQ_READ),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tccb_sweep #(
    .ROWS (ROWS),
    .COLS (COLS),
    .RW   (RW),
    .CW   (CW)
  ) u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (sw_cmd),
    .cmd_row (top_r),
    .busy    (sw_busy),
    .wr_row  (sw_row),
    .wr_col  (sw_col)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cur_row_r <= '0;
      cur_col_r <= '0;
      top_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      top_r     <= top_nxt;
    end
  end

  // read range flag travels with the memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ok_r <= rd_ok;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_now || state_r == ST_READ) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      out_data_r <= res_now;
    end else if (state_r == ST_READ) begin
      out_data_r.cell_char      <= rd_ok_r ? rd_data : '0;
      out_data_r.cursor_row_now <= 5'(cur_row_r);
      out_data_r.cursor_col_now <= 7'(cur_col_r);
      out_data_r.did_scroll     <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // cursor stays inside the grid, column may sit one past the last
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cur_row_r) < ROWS) && (32'(cur_col_r) <= COLS))
    else $error("cursor out of range");

  // read data lands in an empty output slot
  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !out_valid_r)
    else $error("read result would overwrite a pending result");

  // clear homes the cursor and starts the blanking pass
  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.req_type == REQ_CLEAR) |=>
      (cur_row_r == '0 && cur_col_r == '0 && sw_busy && top_r == '0))
    else $error("clear did not home cursor or start sweep");

  // newline on the bottom row reports a scroll and blanks a row
  a_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.req_type == REQ_WRITE && in_data.char_code == CH_NEWLINE &&
     cur_row_r == RW'(ROWS - 1)) |=> (out_data_r.did_scroll && sw_busy && !in_ready))
    else $error("bottom-row newline did not scroll");
`endif

endmodule
